/* design/cbrs_pkg.sv */
// Package for the prefixed rotate/shift/bit unit: operation codes, flag layout,
// cycle charges and the rotate/shift function.
// No dependencies.
package cbrs_pkg;

    localparam int unsigned OperationWidth = 2;
    localparam int unsigned ByteWidth      = 8;
    localparam int unsigned IndexWidth     = 3;
    localparam int unsigned FlagWidth      = 4;
    localparam int unsigned CycleWidth     = 3;
    localparam int unsigned AddrWidth      = 16;
    localparam int unsigned RegCount       = 7;

    // Operation codes of an input word
    typedef enum logic [OperationWidth-1:0] {
        OP_EXEC        = 2'd0,
        OP_WRITE_REG   = 2'd1,
        OP_READ_REG    = 2'd2,
        OP_WRITE_FLAGS = 2'd3
    } t_operation;

    // Rotate/shift selections from opcode bits 5:3
    typedef enum logic [2:0] {
        SH_RLC  = 3'd0,
        SH_RRC  = 3'd1,
        SH_RL   = 3'd2,
        SH_RR   = 3'd3,
        SH_SLA  = 3'd4,
        SH_SRA  = 3'd5,
        SH_SWAP = 3'd6,
        SH_SRL  = 3'd7
    } t_shift_op;

    typedef logic [IndexWidth-1:0] t_slot;
    typedef logic [ByteWidth-1:0]  t_byte;
    typedef logic [FlagWidth-1:0]  t_flags;

    // Operand index that selects the byte at H:L
    localparam logic [IndexWidth-1:0] MEM_INDEX = 3'd6;
    // Operand index of A and the file slot it lives in
    localparam logic [IndexWidth-1:0] A_INDEX   = 3'd7;
    localparam t_slot                 SLOT_A    = 3'd6;
    localparam t_slot                 SLOT_H    = 3'd4;
    localparam t_slot                 SLOT_L    = 3'd5;

    // Flag bit positions
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    // Machine cycles charged
    localparam logic [CycleWidth-1:0] CYC_NONE = 3'd0;
    localparam logic [CycleWidth-1:0] CYC_REG  = 3'd2;
    localparam logic [CycleWidth-1:0] CYC_MEM  = 3'd4;

    // Rotate/shift/swap one byte; returns {carry out, result}
    function automatic logic [ByteWidth:0] shift_byte(input t_shift_op op, input t_byte v,
                                                      input logic c_in);
        logic [ByteWidth:0] res;
        case (op)
            SH_RLC:  res = {v[7], v[6:0], v[7]};
            SH_RRC:  res = {v[0], v[0], v[7:1]};
            SH_RL:   res = {v[7], v[6:0], c_in};
            SH_RR:   res = {v[0], c_in, v[7:1]};
            SH_SLA:  res = {v[7], v[6:0], 1'b0};
            SH_SRA:  res = {v[0], v[7], v[7:1]};
            SH_SWAP: res = {1'b0, v[3:0], v[7:4]};
            SH_SRL:  res = {v[0], 1'b0, v[7:1]};
            default: res = {v[0], 1'b0, v[7:1]};
        endcase
        return res;
    endfunction

endpackage

/* design/cb_rotate_shift_bit_unit.sv */
// Prefixed rotate/shift/swap/BIT execution unit with its register file and flags.
// Depends on cbrs_pkg.
//
//  channel | direction | handshake                 | payload
//  in      | into unit | i_in_valid / o_in_stall   | operation, opcode, reg_index,
//          |           |                           | write_value, mem_value
//  out     | from unit | o_out_valid / i_out_stall | value, flags, store_req,
//          |           |                           | mem_address, cycles_added, handled
//
// One word a cycle while the output is not stalled: a word is held in the input
// register, the execute logic reads and updates the register file and flags, and
// the result is registered. Output stall holds the result register and, once the
// input register is also full, raises o_in_stall. Synchronous reset clears the
// register file, the flags and both valid bits.
module cb_rotate_shift_bit_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [cbrs_pkg::OperationWidth-1:0]  i_operation,
    input  logic [cbrs_pkg::ByteWidth-1:0]       i_opcode,
    input  logic [cbrs_pkg::IndexWidth-1:0]      i_reg_index,
    input  logic [cbrs_pkg::ByteWidth-1:0]       i_write_value,
    input  logic [cbrs_pkg::ByteWidth-1:0]       i_mem_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [cbrs_pkg::ByteWidth-1:0]       o_value,
    output logic [cbrs_pkg::FlagWidth-1:0]       o_flags,
    output logic                                 o_store_req,
    output logic [cbrs_pkg::AddrWidth-1:0]       o_mem_address,
    output logic [cbrs_pkg::CycleWidth-1:0]      o_cycles_added,
    output logic                                 o_handled
);
    import cbrs_pkg::*;

    // Input register
    logic                        r_in_valid;
    logic [OperationWidth-1:0]   r_operation;
    t_byte                       r_opcode;
    logic [IndexWidth-1:0]       r_reg_index;
    t_byte                       r_write_value;
    t_byte                       r_mem_value;

    // Architectural state
    t_byte                       r_regs [RegCount];
    t_flags                      r_flags;

    // Result register
    logic                        r_out_valid;
    t_byte                       r_value;
    t_flags                      r_res_flags;
    logic                        r_store_req;
    logic [AddrWidth-1:0]        r_mem_address;
    logic [CycleWidth-1:0]       r_cycles;
    logic                        r_handled;

    // Execute-stage next values
    t_byte                       n_value;
    t_flags                      n_flags;
    logic                        n_store_req;
    logic [CycleWidth-1:0]       n_cycles;
    logic                        n_handled;
    logic                        n_reg_we;
    t_slot                       n_reg_slot;
    t_byte                       n_reg_data;
    t_byte                       n_h;
    t_byte                       n_l;

    logic                        exec_go;
    logic                        in_take;

    // Advance the execute stage when the result register is free or draining
    assign exec_go    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !exec_go;
    assign in_take    = i_in_valid && !o_in_stall;

    // Map an operand index to a file slot; index 7 (A) maps to slot 6
    function automatic t_slot slot_of(input logic [IndexWidth-1:0] idx);
        return (idx == A_INDEX) ? SLOT_A : t_slot'(idx);
    endfunction

    // Execute one word against the register file and flags
    always_comb begin
        logic [IndexWidth-1:0] operand;
        logic [2:0]            field;
        logic                  is_reg;
        t_slot                 slot;
        t_byte                 src;
        logic [ByteWidth:0]    sh;

        operand = r_opcode[2:0];
        field   = r_opcode[5:3];
        is_reg  = (operand != MEM_INDEX);
        slot    = slot_of(operand);
        src     = is_reg ? r_regs[slot] : r_mem_value;
        sh      = shift_byte(t_shift_op'(field), src, r_flags[FLAG_C]);

        n_value     = '0;
        n_flags     = r_flags;
        n_store_req = 1'b0;
        n_cycles    = CYC_NONE;
        n_handled   = 1'b0;
        n_reg_we    = 1'b0;
        n_reg_slot  = slot;
        n_reg_data  = sh[ByteWidth-1:0];

        case (t_operation'(r_operation))
            OP_EXEC: begin
                if (!r_opcode[7] && !r_opcode[6]) begin
                    // rotate / shift / swap
                    n_value   = sh[ByteWidth-1:0];
                    n_flags   = '0;
                    n_flags[FLAG_Z] = (sh[ByteWidth-1:0] == '0);
                    n_flags[FLAG_C] = sh[ByteWidth];
                    n_handled = 1'b1;
                    if (is_reg) begin
                        n_reg_we = 1'b1;
                        n_cycles = CYC_REG;
                    end else begin
                        n_store_req = 1'b1;
                        n_cycles    = CYC_MEM;
                    end
                end else if (!r_opcode[7] && is_reg) begin
                    // BIT test; carry kept
                    n_value   = src;
                    n_flags[FLAG_Z] = !src[field];
                    n_flags[FLAG_N] = 1'b0;
                    n_flags[FLAG_H] = 1'b1;
                    n_cycles  = CYC_REG;
                    n_handled = 1'b1;
                end
            end
            OP_WRITE_REG: begin
                n_reg_slot = slot_of(r_reg_index);
                n_reg_data = r_write_value;
                if (r_reg_index != MEM_INDEX) begin
                    n_reg_we = 1'b1;
                    n_value  = r_write_value;
                end
            end
            OP_READ_REG: begin
                if (r_reg_index != MEM_INDEX) begin
                    n_value = r_regs[slot_of(r_reg_index)];
                end
            end
            OP_WRITE_FLAGS: begin
                n_flags = r_write_value[FlagWidth-1:0];
            end
            default: begin
                n_flags = r_flags;
            end
        endcase

        // H:L as it stands after this word
        n_h = (n_reg_we && n_reg_slot == SLOT_H) ? n_reg_data : r_regs[SLOT_H];
        n_l = (n_reg_we && n_reg_slot == SLOT_L) ? n_reg_data : r_regs[SLOT_L];
    end

    // Control state: valid bits, register file, flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
            for (int i = 0; i < RegCount; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (exec_go) begin
                r_in_valid <= 1'b0;
            end
            if (exec_go) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
                if (n_reg_we) begin
                    r_regs[n_reg_slot] <= n_reg_data;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture an accepted input word
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_operation   <= i_operation;
            r_opcode      <= i_opcode;
            r_reg_index   <= i_reg_index;
            r_write_value <= i_write_value;
            r_mem_value   <= i_mem_value;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_value       <= n_value;
            r_res_flags   <= n_flags;
            r_store_req   <= n_store_req;
            r_mem_address <= {n_h, n_l};
            r_cycles      <= n_cycles;
            r_handled     <= n_handled;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_value        = r_value;
    assign o_flags        = r_res_flags;
    assign o_store_req    = r_store_req;
    assign o_mem_address  = r_mem_address;
    assign o_cycles_added = r_cycles;
    assign o_handled      = r_handled;

endmodule
